// ===== rtl/tpef_pkg.sv =====
// ----------------------------------------------------------------------------
// tpef_pkg
// Shared types and constants of the touch pen event filter.
// ----------------------------------------------------------------------------
package tpef_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned SampW  = 12;
  localparam int unsigned PosW   = 15;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgW   = 16;

  localparam logic [TimeW-1:0]   TimeReset     = 32'h8000_0000;
  localparam logic [PosW-1:0]    PosReset      = 15'd32000;
  localparam logic [PeriodW-1:0] PeriodReset   = 16'd2;
  localparam logic [SampW-1:0]   DeadbandReset = 12'd20;

  // event kinds
  localparam logic [KindW-1:0] KindDown = 2'd0;
  localparam logic [KindW-1:0] KindDrag = 2'd1;
  localparam logic [KindW-1:0] KindUp   = 2'd2;

  // input modes
  localparam logic ModeEdge   = 1'b0;
  localparam logic ModeSample = 1'b1;

  // configuration register indexes
  localparam logic CfgRepeatPeriod = 1'b0;
  localparam logic CfgMoveDeadband = 1'b1;

  typedef struct packed {
    logic             mode;
    logic             pen_level;
    logic [TimeW-1:0] time_ms;
    logic [SampW-1:0] x_sample;
    logic [SampW-1:0] y_sample;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0] event_kind;
    logic [PosW-1:0]  event_x;
    logic [PosW-1:0]  event_y;
  } res_t;

  typedef struct packed {
    logic [TimeW-1:0] last_edge_time;
    logic             pen_is_down;
    logic             awaiting_first_move;
    logic [PosW-1:0]  last_x;
    logic [PosW-1:0]  last_y;
  } state_t;

  typedef struct packed {
    logic [PeriodW-1:0] repeat_period_ms;
    logic [SampW-1:0]   move_deadband;
  } cfg_t;

endpackage

// ===== rtl/tpef_step.sv =====
// ----------------------------------------------------------------------------
// tpef_step
// Decision logic for one request: edge debounce, pen state and move filter.
// ----------------------------------------------------------------------------
module tpef_step #(
  parameter int unsigned COORD_BITS = 12
) (
  input  tpef_pkg::req_t   req_i,
  input  tpef_pkg::state_t st_i,
  input  tpef_pkg::cfg_t   cfg_i,
  output tpef_pkg::state_t st_o,
  output logic             res_valid_o,
  output tpef_pkg::res_t   res_o
);

  localparam int unsigned MaskBits =
    (COORD_BITS < tpef_pkg::SampW) ? COORD_BITS : tpef_pkg::SampW;

  logic [tpef_pkg::PosW-1:0]  x_m, y_m, dx, dy, band;
  logic [tpef_pkg::TimeW-1:0] elapsed;
  logic                       edge_ok, pen_down, moved;

  always_comb begin
    x_m  = tpef_pkg::PosW'(req_i.x_sample[MaskBits-1:0]);
    y_m  = tpef_pkg::PosW'(req_i.y_sample[MaskBits-1:0]);
    dx   = (x_m > st_i.last_x) ? (x_m - st_i.last_x) : (st_i.last_x - x_m);
    dy   = (y_m > st_i.last_y) ? (y_m - st_i.last_y) : (st_i.last_y - y_m);
    band = tpef_pkg::PosW'(cfg_i.move_deadband);
    moved = (dx > band) || (dy > band);

    // wrapping elapsed time since the last accepted edge
    elapsed = req_i.time_ms - st_i.last_edge_time;
    edge_ok = (elapsed >= tpef_pkg::TimeW'(cfg_i.repeat_period_ms));

    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '{event_kind: tpef_pkg::KindUp, event_x: st_i.last_x,
                    event_y: st_i.last_y};
    pen_down    = st_i.pen_is_down;

    if (req_i.mode == tpef_pkg::ModeEdge && edge_ok) begin
      st_o.last_edge_time = req_i.time_ms;
      if (req_i.pen_level) begin
        st_o.pen_is_down         = 1'b0;
        st_o.awaiting_first_move = 1'b1;
        res_valid_o              = 1'b1;
      end else begin
        st_o.pen_is_down = 1'b1;
        pen_down         = 1'b1;
      end
    end

    // sample handling: plain samples and touch edges that passed the debounce
    if ((req_i.mode == tpef_pkg::ModeSample ||
         (edge_ok && !req_i.pen_level)) && pen_down && moved) begin
      st_o.last_x              = x_m;
      st_o.last_y              = y_m;
      st_o.awaiting_first_move = 1'b0;
      res_valid_o              = 1'b1;
      res_o.event_kind = st_i.awaiting_first_move ? tpef_pkg::KindDown
                                                  : tpef_pkg::KindDrag;
      res_o.event_x    = x_m;
      res_o.event_y    = y_m;
    end
  end

endmodule

// ===== rtl/touch_pen_event_filter.sv =====
// ----------------------------------------------------------------------------
// touch_pen_event_filter
// Turns pen edges and position samples into down, drag and up events.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------
//  in       | in_valid_i/in_ready_o  | in_req_i  (tpef_pkg::req_t)
//  out      | out_valid_o/out_ready_i| out_res_o (tpef_pkg::res_t)
//  cfg      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// one request per cycle while the output is not stalled; a request is held in
// the input register and its event is loaded into the output register as it leaves.
// state is updated when a request leaves the input register.
// reset clears the pen state and loads the default period and deadband.
// a stalled output holds only requests that make an event; others drain.
// ----------------------------------------------------------------------------
module touch_pen_event_filter #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tpef_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tpef_pkg::res_t             out_res_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [tpef_pkg::CfgW-1:0]  cfg_wdata_i
);

  tpef_pkg::req_t   req_q;
  logic             req_vld_q;
  tpef_pkg::res_t   res_q, res_d;
  logic             res_vld_q;
  tpef_pkg::state_t st_q, st_d;
  tpef_pkg::cfg_t   cfg_q;
  logic             res_valid, advance, out_load;

  tpef_step #(.COORD_BITS(COORD_BITS)) u_step (
    .req_i      (req_q),
    .st_i       (st_q),
    .cfg_i      (cfg_q),
    .st_o       (st_d),
    .res_valid_o(res_valid),
    .res_o      (res_d)
  );

  // a request without an event never waits for the output side
  assign advance    = req_vld_q && (!res_valid || !res_vld_q || out_ready_i);
  assign out_load   = advance && res_valid;
  assign in_ready_o = !req_vld_q || advance;

  assign out_valid_o = res_vld_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      st_q      <= '{last_edge_time: tpef_pkg::TimeReset, pen_is_down: 1'b0,
                     awaiting_first_move: 1'b1, last_x: tpef_pkg::PosReset,
                     last_y: tpef_pkg::PosReset};
      cfg_q     <= '{repeat_period_ms: tpef_pkg::PeriodReset,
                     move_deadband: tpef_pkg::DeadbandReset};
    end else begin
      if (in_ready_o) begin
        req_vld_q <= in_valid_i;
      end
      if (out_load) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
      if (advance) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tpef_pkg::CfgRepeatPeriod: cfg_q.repeat_period_ms <= cfg_wdata_i;
          tpef_pkg::CfgMoveDeadband:
            cfg_q.move_deadband <= cfg_wdata_i[tpef_pkg::SampW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_q.event_kind == tpef_pkg::KindDown ||
                   res_q.event_kind == tpef_pkg::KindDrag ||
                   res_q.event_kind == tpef_pkg::KindUp))
    else $error("undefined event kind on output");

  a_up_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_d.event_kind == tpef_pkg::KindUp) |=>
      (!st_q.pen_is_down && st_q.awaiting_first_move))
    else $error("up event did not release the pen");

  a_move_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_d.event_kind != tpef_pkg::KindUp) |=>
      (st_q.pen_is_down && !st_q.awaiting_first_move &&
       res_q.event_x == st_q.last_x && res_q.event_y == st_q.last_y))
    else $error("move event and stored position disagree");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !out_ready_i) |-> !out_load)
    else $error("pending event overwritten");
`endif

endmodule
